// ----- rtl/core/rxd_pkg.sv -----
// Shared types and constants for the rolling XOR packet decryptor.
package rxd_pkg;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 16;
  localparam int KEY_W     = 32;
  localparam int LANE_W    = 2;
  localparam int HDR_W     = 2;
  localparam int WORD_LANES = KEY_W / BYTE_W;

  // Default trailer length, legal range 0 to 4.
  localparam int TRAILER_BYTES_DEF = 2;

  // First byte value that selects the long header.
  localparam logic [BYTE_W-1:0] HDR_LONG_MARK = 8'h00;
  localparam logic [HDR_W-1:0]  HDR_SHORT     = 2'd1;
  localparam logic [HDR_W-1:0]  HDR_LONG      = 2'd2;
  localparam logic [LANE_W-1:0] LAST_LANE     = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              is_first;
    logic [LEN_W-1:0]  packet_length;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              is_last;
  } out_item_t;

endpackage

// ----- rtl/core/rxd_if.sv -----
// Valid/ready channel interfaces for raw and decrypted byte items.
interface rxd_in_if;
  logic                       valid;
  logic                       ready;
  logic [rxd_pkg::BYTE_W-1:0] data_byte;
  logic                       is_first;
  logic [rxd_pkg::LEN_W-1:0]  packet_length;

  modport source (output valid, output data_byte, output is_first, output packet_length,
                  input ready);
  modport sink (input valid, input data_byte, input is_first, input packet_length,
                output ready);
endinterface

interface rxd_out_if;
  logic                       valid;
  logic                       ready;
  logic [rxd_pkg::BYTE_W-1:0] out_byte;
  logic                       is_last;

  modport source (output valid, output out_byte, output is_last, input ready);
  modport sink (input valid, input out_byte, input is_last, output ready);
endinterface

// ----- rtl/core/rxd_in_stage.sv -----
// Input register: holds one raw item until the decrypt step consumes it.
module rxd_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  rxd_pkg::in_item_t in_item,
  output logic              in_ready,
  input  logic              advance,
  output logic              s1_valid,
  output rxd_pkg::in_item_t s1_item
);

  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
  end

endmodule

// ----- rtl/core/rxd_decrypt.sv -----
// Per-packet state, seed register and the rolling XOR byte step.
module rxd_decrypt #(
  parameter int TRAILER_BYTES = rxd_pkg::TRAILER_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [rxd_pkg::KEY_W-1:0]  cfg_wdata,
  input  rxd_pkg::in_item_t          s1_item,
  input  logic                       advance,
  output rxd_pkg::out_item_t         result
);

  localparam int LW = rxd_pkg::LEN_W + 1;
  localparam logic [LW-1:0] TRL = LW'(TRAILER_BYTES);

  logic [rxd_pkg::KEY_W-1:0] key_seed;
  logic [rxd_pkg::KEY_W-1:0] running_key, running_key_next;
  logic [rxd_pkg::KEY_W-1:0] word_gather, word_gather_next;
  logic [rxd_pkg::LEN_W-1:0] byte_position, byte_position_next;
  logic [rxd_pkg::LEN_W-1:0] length_held;
  logic [rxd_pkg::HDR_W-1:0] header_size;

  // Effective state: a first byte restarts the packet.
  logic [rxd_pkg::LEN_W-1:0] pos_e, len_e;
  logic [rxd_pkg::HDR_W-1:0] hs_e;
  logic [rxd_pkg::KEY_W-1:0] key_e, gather_e, gather_upd;
  logic [LW-1:0] pos17, len17, hs17, hs_trl, pay_len, pay_end, full_bytes, q;
  logic has_pay, in_pay, in_full;
  logic [rxd_pkg::LANE_W-1:0] lane;
  logic [rxd_pkg::BYTE_W-1:0] key_byte;

  always_comb begin
    if (s1_item.is_first) begin
      len_e    = s1_item.packet_length;
      hs_e     = (s1_item.data_byte == rxd_pkg::HDR_LONG_MARK) ? rxd_pkg::HDR_LONG
                                                                : rxd_pkg::HDR_SHORT;
      key_e    = key_seed;
      gather_e = '0;
      pos_e    = '0;
    end else begin
      len_e    = length_held;
      hs_e     = header_size;
      key_e    = running_key;
      gather_e = word_gather;
      pos_e    = byte_position;
    end
  end

  always_comb begin
    pos17      = {1'b0, pos_e};
    len17      = {1'b0, len_e};
    hs17       = LW'(hs_e);
    hs_trl     = hs17 + TRL;
    has_pay    = len17 > hs_trl;
    pay_len    = len17 - hs_trl;
    pay_end    = len17 - TRL;
    full_bytes = {pay_len[LW-1:rxd_pkg::LANE_W], {rxd_pkg::LANE_W{1'b0}}};
    q          = pos17 - hs17;
    in_pay     = has_pay && (pos17 >= hs17) && (pos17 < pay_end);
    in_full    = in_pay && (q < full_bytes);
    lane       = q[rxd_pkg::LANE_W-1:0];
    key_byte   = rxd_pkg::BYTE_W'(key_e >> {lane, 3'b000});
  end

  // Replace the active lane of the gathered ciphertext word.
  always_comb begin
    for (int i = 0; i < rxd_pkg::WORD_LANES; i++) begin
      if (lane == rxd_pkg::LANE_W'(i)) begin
        gather_upd[i*rxd_pkg::BYTE_W +: rxd_pkg::BYTE_W] = s1_item.data_byte;
      end else begin
        gather_upd[i*rxd_pkg::BYTE_W +: rxd_pkg::BYTE_W] =
          gather_e[i*rxd_pkg::BYTE_W +: rxd_pkg::BYTE_W];
      end
    end
  end

  always_comb begin
    result.is_last = (pos17 + LW'(1)) == len17;
    if (in_full) begin
      result.out_byte = s1_item.data_byte ^ key_byte;
    end else if (in_pay) begin
      result.out_byte = s1_item.data_byte ^ key_e[rxd_pkg::BYTE_W-1:0];
    end else begin
      result.out_byte = s1_item.data_byte;
    end
    word_gather_next   = in_full ? gather_upd : gather_e;
    running_key_next   = (in_full && lane == rxd_pkg::LAST_LANE) ? gather_upd : key_e;
    byte_position_next = (&pos_e) ? pos_e : pos_e + rxd_pkg::LEN_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_seed <= '0;
    end else if (cfg_we) begin
      key_seed <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_key   <= '0;
      word_gather   <= '0;
      byte_position <= '0;
      length_held   <= '0;
      header_size   <= rxd_pkg::HDR_SHORT;
    end else if (advance) begin
      running_key   <= running_key_next;
      word_gather   <= word_gather_next;
      byte_position <= byte_position_next;
      length_held   <= len_e;
      header_size   <= hs_e;
    end
  end

endmodule

// ----- rtl/core/rxd_out_stage.sv -----
// Result register: holds a decrypted item until the sink takes it.
module rxd_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               s1_valid,
  input  rxd_pkg::out_item_t result,
  output logic               advance,
  output logic               out_valid,
  output rxd_pkg::out_item_t out_item,
  input  logic               out_ready
);

  assign advance = s1_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

endmodule

// ----- rtl/core/rolling_xor_packet_decrypt.sv -----
// Top level: rolling XOR packet decryptor, one byte item per cycle while the sink is ready.
// An accepted item passes through the input register, then the result register.
// Throughput: 1 item per cycle while the sink is ready; the key chain is a single register update
// in the decrypt step, so back-to-back items never wait on each other.
// Reset (rst, synchronous): pipeline empty, seed 0, key/gather/position/length 0,
// header size 1; bytes before any first byte pass through with is_last 0.
module rolling_xor_packet_decrypt #(
  parameter int TRAILER_BYTES = rxd_pkg::TRAILER_BYTES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  rxd_in_if.sink                    cipher,
  rxd_out_if.source                 clear,
  input  logic                      cfg_we,
  input  logic [rxd_pkg::KEY_W-1:0] cfg_wdata
);

  rxd_pkg::in_item_t  in_item;
  rxd_pkg::in_item_t  s1_item;
  rxd_pkg::out_item_t result;
  rxd_pkg::out_item_t out_item;
  logic               s1_valid;
  logic               advance;
  logic               in_ready;
  logic               out_valid;

  // Pack the raw channel into an item.
  assign in_item.data_byte     = cipher.data_byte;
  assign in_item.is_first      = cipher.is_first;
  assign in_item.packet_length = cipher.packet_length;
  assign cipher.ready          = in_ready;

  // Stage 1: raw item register. Ready depends only on whether it is empty or drains.
  rxd_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cipher.valid),
    .in_item  (in_item),
    .in_ready (in_ready),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  // Byte step: header/trailer pass-through, payload XOR, key roll per word.
  rxd_decrypt #(
    .TRAILER_BYTES (TRAILER_BYTES)
  ) u_dec (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s1_item   (s1_item),
    .advance   (advance),
    .result    (result)
  );

  // Stage 2: result register; advance fires whenever an item is held and it is free or draining.
  rxd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .result    (result),
    .advance   (advance),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_ready (clear.ready)
  );

  assign clear.valid    = out_valid;
  assign clear.out_byte = out_item.out_byte;
  assign clear.is_last  = out_item.is_last;

  // An accepted item always lands in the input register.
  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    cipher.valid && in_ready |=> s1_valid)
    else $error("accepted item lost at input register");

  // An empty input register never back-pressures the source.
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input stalled while empty");

  // A held item moves on whenever the result register is free.
  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_valid |-> advance)
    else $error("item stuck with free result register");

  // Every step produces a result on the following cycle.
  a_step_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("step did not produce a result");

endmodule

// ----- dv/tb_rolling_xor_packet_decrypt.sv -----
// Testbench for the rolling XOR packet decryptor: a table of directed bytes, then random packets.
module tb_rolling_xor_packet_decrypt;

  localparam int TRAILER_BYTES = rxd_pkg::TRAILER_BYTES_DEF;
  // Input register plus result register; pad it a little before seed writes.
  localparam int LATENCY       = 2;
  localparam int SEGMENTS      = 8;
  localparam int SEG_ITEMS     = 115;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 2000;
  localparam int SHOW_LIMIT    = 10;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_we;
  logic [rxd_pkg::KEY_W-1:0] cfg_wdata;

  rxd_in_if  cipher_ch ();
  rxd_out_if clear_ch ();

  rolling_xor_packet_decrypt u_top (
    .clk      (clk),
    .rst      (rst),
    .cipher   (cipher_ch),
    .clear    (clear_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the seed register and the packet walker.
  // ---------------------------------------------------------------------------
  logic [rxd_pkg::KEY_W-1:0] seed_shadow;
  logic [rxd_pkg::KEY_W-1:0] roll_key;
  logic [rxd_pkg::KEY_W-1:0] word_acc;
  logic [rxd_pkg::LEN_W-1:0] byte_pos;
  logic [rxd_pkg::LEN_W-1:0] pkt_len;
  logic [rxd_pkg::HDR_W-1:0] hdr_len;

  // Decrypted items still owed by the block, oldest first.
  rxd_pkg::out_item_t clear_q[$];

  // Item on the input bus; rows from the table can pin the result by hand.
  logic               pin_valid;
  rxd_pkg::out_item_t pin_item;

  int  mismatch_cnt = 0;
  int  idle_cnt     = 0;
  int  snd_idle_pct = 0;
  int  rcv_stall_pct = 0;
  bit  hold_req = 1'b0;
  bit  hold_off = 1'b0;

  function automatic void clear_walker();
    seed_shadow = '0;
    roll_key    = '0;
    word_acc    = '0;
    byte_pos    = '0;
    pkt_len     = '0;
    hdr_len     = rxd_pkg::HDR_SHORT;
  endfunction

  // One raw byte in, one output byte out. Header and trailer pass through,
  // full payload words use the rolling key, the tail uses the key's low byte.
  function automatic rxd_pkg::out_item_t predict_clear(input rxd_pkg::in_item_t it);
    rxd_pkg::out_item_t r;
    int unsigned        p, l, h, pay, full, q, lane;
    if (it.is_first) begin
      pkt_len  = it.packet_length;
      hdr_len  = (it.data_byte == rxd_pkg::HDR_LONG_MARK) ? rxd_pkg::HDR_LONG
                                                           : rxd_pkg::HDR_SHORT;
      roll_key = seed_shadow;
      word_acc = '0;
      byte_pos = '0;
    end
    p = byte_pos;
    l = pkt_len;
    h = hdr_len;
    r.out_byte = it.data_byte;
    r.is_last  = (p + 1 == l);
    if (l > h + TRAILER_BYTES) begin
      pay  = l - h - TRAILER_BYTES;
      full = pay & ~32'd3;
      if (p >= h && p < h + pay) begin
        q    = p - h;
        lane = q % rxd_pkg::WORD_LANES;
        if (q < full) begin
          r.out_byte = it.data_byte ^ roll_key[lane*rxd_pkg::BYTE_W +: rxd_pkg::BYTE_W];
          word_acc[lane*rxd_pkg::BYTE_W +: rxd_pkg::BYTE_W] = it.data_byte;
          // key chains on the ciphertext of each completed word
          if (lane == rxd_pkg::LAST_LANE) roll_key = word_acc;
        end else begin
          r.out_byte = it.data_byte ^ roll_key[rxd_pkg::BYTE_W-1:0];
        end
      end
    end
    // position saturates instead of wrapping on very long streams
    if (byte_pos != '1) byte_pos = byte_pos + 1'b1;
    return r;
  endfunction

  function automatic void flag_error(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= SHOW_LIMIT) $display("%0t: %s", $realtime, msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: outputs are checked before the input of the same edge is
  // predicted, so a zero-latency fault still lands on a deterministic order.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : score
    rxd_pkg::out_item_t got;
    rxd_pkg::out_item_t want;
    rxd_pkg::out_item_t pred;
    rxd_pkg::in_item_t  seen;
    if (!rst && clear_ch.valid && clear_ch.ready) begin
      got.out_byte = clear_ch.out_byte;
      got.is_last  = clear_ch.is_last;
      if (clear_q.size() == 0) begin
        flag_error($sformatf("unexpected item out_byte=%02h is_last=%0b",
                             got.out_byte, got.is_last));
      end else begin
        want = clear_q.pop_front();
        if (got.out_byte != want.out_byte || got.is_last != want.is_last)
          flag_error($sformatf(
            "item mismatch: out_byte exp %02h got %02h, is_last exp %0b got %0b",
            want.out_byte, got.out_byte, want.is_last, got.is_last));
      end
    end
    if (!rst && cipher_ch.valid && cipher_ch.ready) begin
      seen.data_byte     = cipher_ch.data_byte;
      seen.is_first      = cipher_ch.is_first;
      seen.packet_length = cipher_ch.packet_length;
      // predictor always runs so its state follows the stream, even on pinned rows
      pred = predict_clear(seen);
      clear_q.push_back(pin_valid ? pin_item : pred);
    end
  end

  // Watchdog: too many cycles with no item moving on either side.
  always @(posedge clk) begin
    if (rst || (cipher_ch.valid && cipher_ch.ready) || (clear_ch.valid && clear_ch.ready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= STALL_LIMIT) begin
      $display("watchdog: no item accepted for %0d cycles, %0d items owed",
               idle_cnt, clear_q.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // Receiver: random back-pressure, or a solid hold-off while pressure is on.
  always @(negedge clk) begin
    if (hold_off) clear_ch.ready <= 1'b0;
    else clear_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  // Long hold-off, timed here so the sender keeps offering and the block backs up.
  initial begin
    @(posedge hold_req);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sender side. Every task is entered and left at a falling edge.
  // ---------------------------------------------------------------------------
  task automatic offer_byte(input rxd_pkg::in_item_t it, input logic pinned,
                            input rxd_pkg::out_item_t want);
    while ($urandom_range(99) < snd_idle_pct) begin
      cipher_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pin_valid = pinned;
    pin_item  = want;
    cipher_ch.valid         <= 1'b1;
    cipher_ch.data_byte     <= it.data_byte;
    cipher_ch.is_first      <= it.is_first;
    cipher_ch.packet_length <= it.packet_length;
    do @(posedge clk); while (!(cipher_ch.valid && cipher_ch.ready));
    @(negedge clk);
  endtask

  // Send cnt bytes of a packet that claims length len. Length on later bytes
  // is junk; the block must only sample it with the first byte.
  task automatic send_frame(input int unsigned len, input int unsigned cnt, ref int sent);
    rxd_pkg::in_item_t  it;
    rxd_pkg::out_item_t none;
    none = '0;
    for (int unsigned i = 0; i < cnt; i++) begin
      it.data_byte     = (i == 0 && $urandom_range(2) == 0) ? rxd_pkg::HDR_LONG_MARK
                                                            : rxd_pkg::BYTE_W'($urandom);
      it.is_first      = (i == 0);
      it.packet_length = (i == 0) ? rxd_pkg::LEN_W'(len) : rxd_pkg::LEN_W'($urandom);
      offer_byte(it, 1'b0, none);
      sent++;
    end
  endtask

  // Mostly well-formed packets of small sizes (every tail length, both header
  // sizes, short packets); the rest cut short, overrun, zero length, or a
  // wild length that never finishes.
  task automatic random_packet(ref int sent);
    int unsigned kind, len, cnt;
    kind = $urandom_range(99);
    len  = $urandom_range(24, 1);
    cnt  = len;
    if (kind < 4) begin
      len = 0;
      cnt = $urandom_range(3, 1);
    end else if (kind < 10) begin
      len = $urandom & 32'hFFFF;
      cnt = $urandom_range(30, 1);
    end else if (kind < 18) begin
      cnt = $urandom_range(len, 1);
    end else if (kind < 26) begin
      cnt = len + $urandom_range(3, 1);
    end
    send_frame(len, cnt, sent);
  endtask

  // Seed writes only with the pipe empty.
  task automatic drain();
    cipher_ch.valid <= 1'b0;
    while (clear_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  task automatic load_seed(input logic [rxd_pkg::KEY_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    seed_shadow = v;
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  typedef struct {
    rxd_pkg::in_item_t  raw;
    logic               pinned;
    rxd_pkg::out_item_t want;
  } row_t;

  row_t table_q[$];

  function automatic void add_row(input logic [7:0] d, input logic f, input logic [15:0] len,
                                  input logic pinned, input logic [7:0] wb, input logic wl);
    row_t r;
    r.raw.data_byte     = d;
    r.raw.is_first      = f;
    r.raw.packet_length = len;
    r.pinned            = pinned;
    r.want.out_byte     = wb;
    r.want.is_last      = wl;
    table_q.push_back(r);
  endfunction

  initial begin : stim
    int sent;
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    cipher_ch.valid  = 1'b0;
    cipher_ch.data_byte     = '0;
    cipher_ch.is_first      = 1'b0;
    cipher_ch.packet_length = '0;
    pin_valid        = 1'b0;
    pin_item         = '0;
    clear_walker();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Stray bytes right after reset: treated as a zero-length packet.
    add_row(8'hA5, 1'b0, 16'h0000, 1'b1, 8'hA5, 1'b0);
    add_row(8'hFF, 1'b0, 16'hFFFF, 1'b1, 8'hFF, 1'b0);
    // Short packet, no payload room: all bytes pass, then one byte past the end.
    add_row(8'h37, 1'b1, 16'd3, 1'b1, 8'h37, 1'b0);
    add_row(8'h12, 1'b0, 16'd0, 1'b1, 8'h12, 1'b0);
    add_row(8'h34, 1'b0, 16'd0, 1'b1, 8'h34, 1'b1);
    add_row(8'h56, 1'b0, 16'd0, 1'b1, 8'h56, 1'b0);
    // Zero length with a long header: never flags the last byte.
    add_row(8'h00, 1'b1, 16'd0, 1'b1, 8'h00, 1'b0);
    add_row(8'hFF, 1'b0, 16'd0, 1'b1, 8'hFF, 1'b0);
    // Long header, one full word, a three byte tail, trailer.
    add_row(8'h00, 1'b1, 16'd11, 1'b1, 8'h00, 1'b0);
    add_row(8'h11, 1'b0, 16'd0, 1'b1, 8'h11, 1'b0);
    add_row(8'hA1, 1'b0, 16'd0, 1'b0, 8'h00, 1'b0);
    add_row(8'hB2, 1'b0, 16'd0, 1'b0, 8'h00, 1'b0);
    add_row(8'hC3, 1'b0, 16'd0, 1'b0, 8'h00, 1'b0);
    add_row(8'hD4, 1'b0, 16'd0, 1'b0, 8'h00, 1'b0);
    add_row(8'hE5, 1'b0, 16'd0, 1'b0, 8'h00, 1'b0);
    add_row(8'hF6, 1'b0, 16'd0, 1'b0, 8'h00, 1'b0);
    add_row(8'h07, 1'b0, 16'd0, 1'b0, 8'h00, 1'b0);
    add_row(8'h88, 1'b0, 16'd0, 1'b1, 8'h88, 1'b0);
    add_row(8'h99, 1'b0, 16'd0, 1'b1, 8'h99, 1'b1);
    // Max length, abandoned after two payload bytes by a restart.
    add_row(8'hFF, 1'b1, 16'hFFFF, 1'b1, 8'hFF, 1'b0);
    add_row(8'h80, 1'b0, 16'd0, 1'b0, 8'h00, 1'b0);
    add_row(8'h7F, 1'b0, 16'd0, 1'b0, 8'h00, 1'b0);
    add_row(8'h42, 1'b1, 16'd1, 1'b1, 8'h42, 1'b1);
    // Long header that eats the whole packet.
    add_row(8'h00, 1'b1, 16'd2, 1'b1, 8'h00, 1'b0);
    add_row(8'h5A, 1'b0, 16'd0, 1'b1, 8'h5A, 1'b1);

    foreach (table_q[i]) offer_byte(table_q[i].raw, table_q[i].pinned, table_q[i].want);
    pin_valid = 1'b0;

    // Random segments, each with its own seed and idling mode:
    // none, sender gaps, receiver stalls, both.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      drain();
      case (seg)
        0:       load_seed('1);
        1:       load_seed('0);
        default: load_seed(rxd_pkg::KEY_W'($urandom));
      endcase
      case (seg % 4)
        0: begin snd_idle_pct = 0;  rcv_stall_pct <= 0;  end
        1: begin snd_idle_pct = 57; rcv_stall_pct <= 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct <= 57; end
        default: begin snd_idle_pct = 29; rcv_stall_pct <= 29; end
      endcase
      @(negedge clk);
      if (seg == 4) hold_req <= 1'b1;
      sent = 0;
      while (sent < SEG_ITEMS) random_packet(sent);
    end

    drain();
    repeat (4 * LATENCY) @(posedge clk);
    if (clear_q.size() != 0)
      flag_error($sformatf("%0d expected items never came out", clear_q.size()));

    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
